FILE: src/sra_pkg.sv
// Shared types, constants and the sail curve for the sail/rudder autopilot step.
// Used by the channel interfaces, the top level and the checker.
`default_nettype none
package sra_pkg;

	// heel moving sum
	localparam int HeelWindow = 15;
	localparam int SlotW      = $clog2(HeelWindow);
	localparam int SampleW    = 6;
	localparam int SumW       = SampleW + $clog2(HeelWindow);
	localparam int HeelBias   = 3 * HeelWindow;
	localparam int HeelMax    = 5;
	localparam int HeelEstW   = 3;

	// field widths
	localparam int HeadingW = 9;
	localparam int AngleW   = 8;
	localparam int DbW      = 6;
	localparam int SailW    = 7;
	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 8;

	localparam logic [AngleW-1:0] WindMax = AngleW'(180);

	typedef enum logic [CfgIdxW-1:0] {
		CFG_RUDDER_CENTER      = 3'd0,
		CFG_HEADING_DEADBAND   = 3'd1,
		CFG_RUDDER_MIN         = 3'd2,
		CFG_RUDDER_MAX         = 3'd3,
		CFG_WIND_DEADBAND      = 3'd4,
		CFG_CLOSE_HAULED_ANGLE = 3'd5,
		CFG_BEAM_REACH_ANGLE   = 3'd6,
		CFG_BROAD_REACH_ANGLE  = 3'd7
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ACT_HEADING      = 2'd0,
		ACT_CLOSE_HAULED = 2'd1,
		ACT_BEAM_REACH   = 2'd2,
		ACT_BROAD_REACH  = 2'd3
	} action_t;

	// signed working width for headings and rudder arithmetic
	typedef logic signed [12:0] hv_t;
	localparam hv_t HeadingWrap = hv_t'(360);
	localparam hv_t RudderTop   = hv_t'(255);

	// wind angles at which the sail position steps up by one
	localparam int SailSteps = 29;
	typedef logic [AngleW-1:0] step_tbl_t [SailSteps];
	localparam step_tbl_t SailStepAt = '{
		8'd48,  8'd57,  8'd63,  8'd68,  8'd73,  8'd77,  8'd81,  8'd84,  8'd87,  8'd91,
		8'd94,  8'd96,  8'd99,  8'd102, 8'd105, 8'd108, 8'd111, 8'd114, 8'd117, 8'd120,
		8'd123, 8'd127, 8'd131, 8'd135, 8'd140, 8'd146, 8'd153, 8'd163, 8'd179
	};
	localparam logic [SailW-1:0] SailBase = SailW'(60);

	function automatic logic [SailW-1:0] sail_of_wind(input logic [AngleW-1:0] w);
		logic [SailW-1:0] pos;
		pos = SailBase;
		for (int i = 0; i < SailSteps; i++) begin
			if (w >= SailStepAt[i])
				pos = pos + SailW'(1);
		end
		return pos;
	endfunction

	// when the bounds cross, the high bound wins unless x is below the low bound
	function automatic hv_t clamp_lo_hi(input hv_t x, input hv_t lo, input hv_t hi);
		hv_t r;
		if (x < lo)
			r = lo;
		else if (x > hi)
			r = hi;
		else
			r = x;
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: src/sra_sensor_if.sv
// Input channel of the autopilot step: one control tick per word.
// Depends on sra_pkg for field widths.
`default_nettype none
interface sra_sensor_if;
	logic                                valid;
	logic                                ready;
	logic [1:0]                          action;
	logic [sra_pkg::HeadingW-1:0]        target_heading;
	logic [sra_pkg::HeadingW-1:0]        current_heading;
	logic [sra_pkg::AngleW-1:0]          wind_direction;
	logic                                wind_from_port;
	logic signed [sra_pkg::SampleW-1:0]  heel_sample;

	modport source(output valid, output action, output target_heading,
		output current_heading, output wind_direction, output wind_from_port,
		output heel_sample, input ready);
	modport sink(input valid, input action, input target_heading,
		input current_heading, input wind_direction, input wind_from_port,
		input heel_sample, output ready);
endinterface
`default_nettype wire

FILE: src/sra_servo_if.sv
// Output channel of the autopilot step: rudder, sail and heel estimate per word.
// Depends on sra_pkg for field widths.
`default_nettype none
interface sra_servo_if;
	logic                           valid;
	logic                           ready;
	logic [sra_pkg::AngleW-1:0]     rudder_position;
	logic [sra_pkg::SailW-1:0]      sail_position;
	logic [sra_pkg::HeelEstW-1:0]   heel_estimate;

	modport source(output valid, output rudder_position, output sail_position,
		output heel_estimate, input ready);
	modport sink(input valid, input rudder_position, input sail_position,
		input heel_estimate, output ready);
endinterface
`default_nettype wire

FILE: src/sail_rudder_autopilot_step.sv
// Sail and rudder autopilot step: heel moving sum, steering and sail curve.
// Depends on sra_pkg, sra_sensor_if and sra_servo_if.
//
// Usage:
//   sensor carries one control tick per word (mode, headings, wind, heel sample);
//   servo returns exactly one word per tick, in order: rudder position, sail
//   position and heel estimate.
//   A tick accepted on sensor is registered in the input stage; the result is
//   loaded into the output register once that register is free, and the word
//   is then valid on servo.
//   Throughput is one tick per cycle while servo does not stall: the heel
//   window, its running sum and the slot pointer update at acceptance, and the
//   steering logic sits between the input stage and the output register.
//   When servo stalls, the output register holds its word and the input stage
//   holds one more tick; sensor.ready drops only when both are full.
//   Configuration is to be written via cfg_we/cfg_index/cfg_data while no tick
//   is in flight (not enforced); each register applies to ticks computed later.
//   Reset (arst_n low) empties both stages, clears the heel window, sum and
//   slot, and loads the default configuration.
`default_nettype none
module sail_rudder_autopilot_step (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	sra_sensor_if.sink                           sensor,
	sra_servo_if.source                          servo,
	input  wire logic                            cfg_we,
	input  wire logic [sra_pkg::CfgIdxW-1:0]     cfg_index,
	input  wire logic [sra_pkg::CfgDataW-1:0]    cfg_data
);

	// configuration
	logic [sra_pkg::AngleW-1:0] rudder_center_q, rudder_min_q, rudder_max_q;
	logic [sra_pkg::AngleW-1:0] close_hauled_q, beam_reach_q, broad_reach_q;
	logic [sra_pkg::DbW-1:0]    heading_db_q, wind_db_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rudder_center_q <= 8'd98;
			heading_db_q    <= 6'd5;
			rudder_min_q    <= 8'd55;
			rudder_max_q    <= 8'd130;
			wind_db_q       <= 6'd5;
			close_hauled_q  <= 8'd50;
			beam_reach_q    <= 8'd90;
			broad_reach_q   <= 8'd135;
		end else if (cfg_we) begin
			case (sra_pkg::cfg_idx_t'(cfg_index))
				sra_pkg::CFG_RUDDER_CENTER:      rudder_center_q <= cfg_data;
				sra_pkg::CFG_HEADING_DEADBAND:   heading_db_q    <= cfg_data[sra_pkg::DbW-1:0];
				sra_pkg::CFG_RUDDER_MIN:         rudder_min_q    <= cfg_data;
				sra_pkg::CFG_RUDDER_MAX:         rudder_max_q    <= cfg_data;
				sra_pkg::CFG_WIND_DEADBAND:      wind_db_q       <= cfg_data[sra_pkg::DbW-1:0];
				sra_pkg::CFG_CLOSE_HAULED_ANGLE: close_hauled_q  <= cfg_data;
				sra_pkg::CFG_BEAM_REACH_ANGLE:   beam_reach_q    <= cfg_data;
				sra_pkg::CFG_BROAD_REACH_ANGLE:  broad_reach_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// handshake
	logic valid_s1, out_valid_q;
	logic out_free, adv_s1, accept;

	assign out_free     = !out_valid_q || servo.ready;
	assign adv_s1       = valid_s1 && out_free;
	assign sensor.ready = !valid_s1 || out_free;
	assign accept       = sensor.valid && sensor.ready;

	// heel window and running sum
	logic signed [sra_pkg::SampleW-1:0] window_q [sra_pkg::HeelWindow];
	logic signed [sra_pkg::SumW-1:0]    sum_q, sum_next;
	logic [sra_pkg::SlotW-1:0]          slot_q;

	assign sum_next = sum_q
		- sra_pkg::SumW'(window_q[slot_q])
		+ sra_pkg::SumW'(sensor.heel_sample);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < sra_pkg::HeelWindow; i++)
				window_q[i] <= '0;
			sum_q  <= '0;
			slot_q <= '0;
		end else if (accept) begin
			window_q[slot_q] <= sensor.heel_sample;
			sum_q            <= sum_next;
			if (slot_q == sra_pkg::SlotW'(sra_pkg::HeelWindow - 1))
				slot_q <= '0;
			else
				slot_q <= slot_q + sra_pkg::SlotW'(1);
		end
	end

	// input stage
	logic [1:0]                       action_s1;
	logic [sra_pkg::HeadingW-1:0]     target_s1, cur_s1;
	logic [sra_pkg::AngleW-1:0]       wind_s1;
	logic                             port_s1;
	logic signed [sra_pkg::SumW-1:0]  sum_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (sensor.ready)
			valid_s1 <= sensor.valid;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1 <= sensor.action;
			target_s1 <= sensor.target_heading;
			cur_s1    <= sensor.current_heading;
			wind_s1   <= sensor.wind_direction;
			port_s1   <= sensor.wind_from_port;
			sum_s1    <= sum_next;
		end
	end

	// heel estimate: |sum - bias| / window, clamped
	logic signed [sra_pkg::SumW:0]   heel_diff;
	logic [sra_pkg::SumW:0]          heel_mag;
	logic [sra_pkg::HeelEstW-1:0]    heel_est;

	always_comb begin
		heel_diff = (sra_pkg::SumW+1)'(sum_s1) - (sra_pkg::SumW+1)'(sra_pkg::HeelBias);
		heel_mag  = heel_diff[sra_pkg::SumW] ? (sra_pkg::SumW+1)'(-heel_diff)
			: (sra_pkg::SumW+1)'(heel_diff);
		heel_est = '0;
		for (int k = 1; k <= sra_pkg::HeelMax; k++) begin
			if (heel_mag >= (sra_pkg::SumW+1)'(k * sra_pkg::HeelWindow))
				heel_est = sra_pkg::HeelEstW'(k);
		end
	end

	// steering
	logic [sra_pkg::AngleW-1:0] wind_sat, want_angle;
	sra_pkg::hv_t w_v, a_v, wdb_v, cur_v, h_raw, h_v, c_v, hdb_v, heel_v, r_v;

	always_comb begin
		wind_sat = (wind_s1 > sra_pkg::WindMax) ? sra_pkg::WindMax : wind_s1;
		case (sra_pkg::action_t'(action_s1))
			sra_pkg::ACT_CLOSE_HAULED: want_angle = close_hauled_q;
			sra_pkg::ACT_BEAM_REACH:   want_angle = beam_reach_q;
			default:                   want_angle = broad_reach_q;
		endcase
		w_v    = sra_pkg::hv_t'({5'b0, wind_sat});
		a_v    = sra_pkg::hv_t'({5'b0, want_angle});
		wdb_v  = sra_pkg::hv_t'({7'b0, wind_db_q});
		cur_v  = sra_pkg::hv_t'({4'b0, cur_s1});
		c_v    = sra_pkg::hv_t'({5'b0, rudder_center_q});
		hdb_v  = sra_pkg::hv_t'({7'b0, heading_db_q});
		heel_v = sra_pkg::hv_t'({10'b0, heel_est});

		// build the heading to steer
		if (sra_pkg::action_t'(action_s1) == sra_pkg::ACT_HEADING)
			h_raw = sra_pkg::hv_t'({4'b0, target_s1});
		else if (w_v >= a_v - wdb_v && w_v <= a_v + wdb_v)
			h_raw = cur_v;
		else if (w_v < a_v - wdb_v)
			h_raw = port_s1 ? (a_v - w_v) + cur_v : (a_v - w_v) - cur_v;
		else
			h_raw = port_s1 ? (w_v - a_v) - cur_v : (w_v - a_v) + cur_v;

		// single wrap into range
		if (h_raw < 0)
			h_v = h_raw + sra_pkg::HeadingWrap;
		else if (h_raw > sra_pkg::HeadingWrap)
			h_v = h_raw - sra_pkg::HeadingWrap;
		else
			h_v = h_raw;

		if (cur_v >= h_v - hdb_v && cur_v <= h_v + hdb_v)
			r_v = sra_pkg::clamp_lo_hi(port_s1 ? c_v + heel_v : c_v - heel_v,
				'0, sra_pkg::RudderTop);
		else if (cur_v < h_v - hdb_v)
			r_v = sra_pkg::clamp_lo_hi(c_v - (h_v - cur_v),
				sra_pkg::hv_t'({5'b0, rudder_min_q}), c_v);
		else
			r_v = sra_pkg::clamp_lo_hi(c_v + (cur_v - h_v),
				c_v, sra_pkg::hv_t'({5'b0, rudder_max_q}));
	end

	// output register
	logic [sra_pkg::AngleW-1:0]   rudder_q;
	logic [sra_pkg::SailW-1:0]    sail_q;
	logic [sra_pkg::HeelEstW-1:0] heel_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_free)
			out_valid_q <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			rudder_q <= r_v[sra_pkg::AngleW-1:0];
			sail_q   <= sra_pkg::sail_of_wind(wind_sat);
			heel_q   <= heel_est;
		end
	end

	assign servo.valid           = out_valid_q;
	assign servo.rudder_position = rudder_q;
	assign servo.sail_position   = sail_q;
	assign servo.heel_estimate   = heel_q;

endmodule
`default_nettype wire

FILE: src/sra_checker.sv
// Port-level checks for the autopilot step, bound to the top level.
// Depends on sra_pkg for field widths.
`default_nettype none
module sra_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           servo_valid,
	input wire logic                           servo_ready,
	input wire logic [sra_pkg::AngleW-1:0]     rudder_position,
	input wire logic [sra_pkg::SailW-1:0]      sail_position,
	input wire logic [sra_pkg::HeelEstW-1:0]   heel_estimate
);

	// stalled word stays
	a_servo_hold: assert property (@(posedge clk) disable iff (!arst_n)
		servo_valid && !servo_ready |=> servo_valid)
		else $error("servo word dropped while stalled");

	a_servo_stable: assert property (@(posedge clk) disable iff (!arst_n)
		servo_valid && !servo_ready |=>
			$stable(rudder_position) && $stable(sail_position) && $stable(heel_estimate))
		else $error("servo payload changed while stalled");

	// heel estimate is clamped
	a_heel_range: assert property (@(posedge clk) disable iff (!arst_n)
		servo_valid |-> heel_estimate <= sra_pkg::HeelEstW'(sra_pkg::HeelMax))
		else $error("heel estimate out of range");

	// sail curve spans base .. base + steps
	a_sail_range: assert property (@(posedge clk) disable iff (!arst_n)
		servo_valid |-> sail_position >= sra_pkg::SailBase
			&& sail_position <= sra_pkg::SailBase + sra_pkg::SailW'(sra_pkg::SailSteps))
		else $error("sail position out of range");

endmodule

bind sail_rudder_autopilot_step sra_checker u_sra_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.servo_valid     (servo.valid),
	.servo_ready     (servo.ready),
	.rudder_position (servo.rudder_position),
	.sail_position   (servo.sail_position),
	.heel_estimate   (servo.heel_estimate)
);
`default_nettype wire

FILE: tb/sv/sra_step_checker.sv
// Checker for the sail/rudder autopilot step: watches both channels and the register port,
// predicts every servo word and compares it field by field. Depends on sra_pkg and the
// sra_sensor_if / sra_servo_if interfaces.
module sra_step_checker
	import sra_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	sra_sensor_if               sensor,
	sra_servo_if                servo,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	output int                  errors,
	output int                  pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [AngleW-1:0]   rudder;
		logic [SailW-1:0]    sail;
		logic [HeelEstW-1:0] heel;
	} servo_word_t;

	servo_word_t servo_q[$];
	int          setting [8];
	int          heel_ring [HeelWindow];
	int          heel_total;
	int          ring_pos;
	int          word_no;

	function automatic int bound(input int x, input int lo, input int hi);
		int r;
		if (x < lo)
			r = lo;
		else if (x > hi)
			r = hi;
		else
			r = x;
		return r;
	endfunction

	function automatic int steer_rudder(input int h, input int cur, input bit port,
		input int heel);
		int c;
		int db;
		int r;
		c  = setting[CFG_RUDDER_CENTER];
		db = setting[CFG_HEADING_DEADBAND];
		// single wrap only, out-of-range headings pass through
		if (h < 0)
			h = h + 360;
		else if (h > 360)
			h = h - 360;
		if (cur >= h - db && cur <= h + db)
			r = bound(port ? c + heel : c - heel, 0, 255);
		else if (cur < h - db)
			r = bound(c - (h - cur), setting[CFG_RUDDER_MIN], c);
		else
			r = bound(c + (cur - h), c, setting[CFG_RUDDER_MAX]);
		return r;
	endfunction

	function automatic int sail_for_wind(input int w);
		int pos;
		pos = 60;
		for (int i = 0; i < SailSteps; i++) begin
			if (w >= int'(SailStepAt[i]))
				pos++;
		end
		return pos;
	endfunction

	// advance the heel window by one sample and return the clamped estimate
	function automatic int heel_push(input int s);
		int d;
		if (ring_pos >= HeelWindow)
			ring_pos = 0;
		heel_total = heel_total - heel_ring[ring_pos] + s;
		heel_ring[ring_pos] = s;
		ring_pos++;
		if (ring_pos >= HeelWindow)
			ring_pos = 0;
		d = heel_total - HeelBias;
		if (d < 0)
			d = -d;
		d = d / HeelWindow;
		return (d > HeelMax) ? HeelMax : d;
	endfunction

	function automatic servo_word_t autopilot_tick();
		servo_word_t o;
		int cur;
		int w;
		int heel;
		int angle;
		int db;
		int h;
		int r;
		bit port;
		cur  = int'(sensor.current_heading);
		w    = (sensor.wind_direction > WindMax) ? int'(WindMax) : int'(sensor.wind_direction);
		port = sensor.wind_from_port;
		heel = heel_push(int'(sensor.heel_sample));
		case (action_t'(sensor.action))
		ACT_HEADING: begin
			r = steer_rudder(int'(sensor.target_heading), cur, port, heel);
		end
		default: begin
			case (action_t'(sensor.action))
			ACT_CLOSE_HAULED: angle = setting[CFG_CLOSE_HAULED_ANGLE];
			ACT_BEAM_REACH:   angle = setting[CFG_BEAM_REACH_ANGLE];
			default:          angle = setting[CFG_BROAD_REACH_ANGLE];
			endcase
			db = setting[CFG_WIND_DEADBAND];
			if (w >= angle - db && w <= angle + db)
				h = cur;
			else if (w < angle - db)
				h = port ? (angle - w) + cur : (angle - w) - cur;
			else
				h = port ? (w - angle) - cur : (w - angle) + cur;
			r = steer_rudder(h, cur, port, heel);
		end
		endcase
		o.rudder = AngleW'(r);
		o.sail   = SailW'(sail_for_wind(w));
		o.heel   = HeelEstW'(heel);
		return o;
	endfunction

	task automatic report_fault(input string msg);
		$display("%0t ns servo word %0d: %s", $time, word_no, msg);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		servo_word_t want;
		if (!arst_n) begin
			setting[CFG_RUDDER_CENTER]      = 98;
			setting[CFG_HEADING_DEADBAND]   = 5;
			setting[CFG_RUDDER_MIN]         = 55;
			setting[CFG_RUDDER_MAX]         = 130;
			setting[CFG_WIND_DEADBAND]      = 5;
			setting[CFG_CLOSE_HAULED_ANGLE] = 50;
			setting[CFG_BEAM_REACH_ANGLE]   = 90;
			setting[CFG_BROAD_REACH_ANGLE]  = 135;
			for (int i = 0; i < HeelWindow; i++)
				heel_ring[i] = 0;
			heel_total = 0;
			ring_pos   = 0;
			word_no    = 0;
			errors     = 0;
			servo_q.delete();
			pending = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
				CFG_HEADING_DEADBAND, CFG_WIND_DEADBAND: begin
					setting[cfg_index] = int'(cfg_data[DbW-1:0]);
				end
				default: begin
					setting[cfg_index] = int'(cfg_data);
				end
				endcase
			end
			if (servo.valid && servo.ready) begin
				if (servo_q.size() == 0) begin
					report_fault("word with no tick outstanding");
				end else begin
					want = servo_q.pop_front();
					if (servo.rudder_position !== want.rudder)
						report_fault($sformatf("rudder_position %0d, expected %0d",
							servo.rudder_position, want.rudder));
					if (servo.sail_position !== want.sail)
						report_fault($sformatf("sail_position %0d, expected %0d",
							servo.sail_position, want.sail));
					if (servo.heel_estimate !== want.heel)
						report_fault($sformatf("heel_estimate %0d, expected %0d",
							servo.heel_estimate, want.heel));
				end
				word_no++;
			end
			if (sensor.valid && sensor.ready)
				servo_q.push_back(autopilot_tick());
			pending = servo_q.size();
		end
	end

endmodule

FILE: tb/sv/tb_sail_rudder_autopilot_step.sv
// Top of the autopilot step testbench: clock, reset, register writes and sensor/servo traffic.
// Depends on sra_pkg, the channel interfaces, the block and sra_step_checker.
module tb_sail_rudder_autopilot_step
	import sra_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HoldCycles     = 60;
	localparam int RandomPerPhase = 225;

	typedef struct {
		action_t                    action;
		logic [HeadingW-1:0]        target;
		logic [HeadingW-1:0]        cur;
		logic [AngleW-1:0]          wind;
		logic                       port;
		logic signed [SampleW-1:0]  heel;
	} tick_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [CfgDataW-1:0] cfg_data;
	int                  errors;
	int                  pending;

	// register values as last written, used to aim stimulus near the deadbands
	int setting [8];
	int heel_bias;
	bit tx_calm;
	bit rx_calm;
	bit hold_req;

	sra_sensor_if sensor();
	sra_servo_if  servo();

	sail_rudder_autopilot_step uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sensor    (sensor),
		.servo     (servo),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	sra_step_checker step_chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.sensor    (sensor),
		.servo     (servo),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.errors    (errors),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("sail_rudder_autopilot_step regression: fail");
		$finish;
	end

	function automatic tick_t tick_of(input action_t a, input int target, input int cur,
		input int wind, input bit port, input int heel);
		tick_t t;
		t.action = a;
		t.target = HeadingW'(target);
		t.cur    = HeadingW'(cur);
		t.wind   = AngleW'(wind);
		t.port   = port;
		t.heel   = SampleW'(heel);
		return t;
	endfunction

	function automatic tick_t random_tick();
		int a;
		int cur;
		int target;
		int wind;
		int heel;
		int db;
		int angle;
		a   = $urandom_range(0, 3);
		cur = ($urandom_range(0, 99) < 8) ? $urandom_range(0, 511) : $urandom_range(0, 359);
		if (a == ACT_HEADING && $urandom_range(0, 1) == 1) begin
			db     = setting[CFG_HEADING_DEADBAND];
			target = cur + $urandom_range(0, 2 * db + 8) - db - 4;
			if (target < 0)
				target = target + 360;
		end else begin
			target = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 511)
				: $urandom_range(0, 360);
		end
		if (a != ACT_HEADING && $urandom_range(0, 1) == 1) begin
			case (action_t'(a))
			ACT_CLOSE_HAULED: angle = setting[CFG_CLOSE_HAULED_ANGLE];
			ACT_BEAM_REACH:   angle = setting[CFG_BEAM_REACH_ANGLE];
			default:          angle = setting[CFG_BROAD_REACH_ANGLE];
			endcase
			db   = setting[CFG_WIND_DEADBAND];
			wind = angle + $urandom_range(0, 2 * db + 12) - db - 6;
			if (wind < 0)
				wind = 0;
			else if (wind > 255)
				wind = 255;
		end else begin
			wind = ($urandom_range(0, 99) < 15) ? $urandom_range(0, 255) : $urandom_range(0, 180);
		end
		if ($urandom_range(0, 99) < 8) begin
			heel = $urandom_range(0, 63) - 32;
		end else begin
			heel = heel_bias + $urandom_range(0, 6) - 3;
			heel = (heel > 20) ? 20 : (heel < -20) ? -20 : heel;
		end
		return tick_of(action_t'(a), target, cur, wind, $urandom_range(0, 1), heel);
	endfunction

	// every call starts and ends on a falling edge
	task automatic send_tick(input tick_t t);
		int gap;
		gap = tx_calm ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			sensor.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		sensor.action          <= t.action;
		sensor.target_heading  <= t.target;
		sensor.current_heading <= t.cur;
		sensor.wind_direction  <= t.wind;
		sensor.wind_from_port  <= t.port;
		sensor.heel_sample     <= t.heel;
		sensor.valid           <= 1'b1;
		do @(posedge clk); while (!sensor.ready);
		@(negedge clk);
	endtask

	task automatic drain();
		sensor.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic cfg_write(input cfg_idx_t idx, input int value);
		cfg_we        <= 1'b1;
		cfg_index     <= idx;
		cfg_data      <= CfgDataW'(value);
		setting[idx]  = value;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic apply_setting(input int center, input int hdb, input int rmin,
		input int rmax, input int wdb, input int close_hauled, input int beam,
		input int broad);
		cfg_write(CFG_RUDDER_CENTER, center);
		cfg_write(CFG_HEADING_DEADBAND, hdb);
		cfg_write(CFG_RUDDER_MIN, rmin);
		cfg_write(CFG_RUDDER_MAX, rmax);
		cfg_write(CFG_WIND_DEADBAND, wdb);
		cfg_write(CFG_CLOSE_HAULED_ANGLE, close_hauled);
		cfg_write(CFG_BEAM_REACH_ANGLE, beam);
		cfg_write(CFG_BROAD_REACH_ANGLE, broad);
	endtask

	task automatic run_random(input int count, input bit squeeze);
		for (int i = 0; i < count; i++) begin
			// new heel trend and idling mood every 40 ticks
			if (i % 40 == 0) begin
				heel_bias = $urandom_range(0, 40) - 20;
				tx_calm   = ($urandom_range(0, 3) == 0);
				rx_calm   = ($urandom_range(0, 3) == 0);
			end
			if (squeeze && i == count / 3) begin
				tx_calm  = 1'b1;
				hold_req = 1'b1;
			end
			if (squeeze && i == 2 * count / 3)
				drain();
			send_tick(random_tick());
		end
	endtask

	// servo side: random stall per word, one long hold on request
	initial begin : servo_sink
		int stall;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (hold_req) begin
				servo.ready <= 1'b0;
				repeat (HoldCycles) @(negedge clk);
				hold_req = 1'b0;
			end
			stall = rx_calm ? 0 : $urandom_range(0, 4);
			if (stall > 0) begin
				servo.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			servo.ready <= 1'b1;
			do @(posedge clk); while (!servo.valid);
			@(negedge clk);
		end
	end

	initial begin
		arst_n                 = 1'b0;
		cfg_we                 = 1'b0;
		cfg_index              = CFG_RUDDER_CENTER;
		cfg_data               = '0;
		sensor.valid           = 1'b0;
		sensor.action          = ACT_HEADING;
		sensor.target_heading  = '0;
		sensor.current_heading = '0;
		sensor.wind_direction  = '0;
		sensor.wind_from_port  = 1'b0;
		sensor.heel_sample     = '0;
		servo.ready            = 1'b0;
		hold_req               = 1'b0;
		tx_calm                = 1'b0;
		rx_calm                = 1'b0;
		heel_bias              = 0;
		setting[CFG_RUDDER_CENTER]      = 98;
		setting[CFG_HEADING_DEADBAND]   = 5;
		setting[CFG_RUDDER_MIN]         = 55;
		setting[CFG_RUDDER_MAX]         = 130;
		setting[CFG_WIND_DEADBAND]      = 5;
		setting[CFG_CLOSE_HAULED_ANGLE] = 50;
		setting[CFG_BEAM_REACH_ANGLE]   = 90;
		setting[CFG_BROAD_REACH_ANGLE]  = 135;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset configuration; heel window still filling
		send_tick(tick_of(ACT_HEADING, 0, 0, 0, 0, 0));
		send_tick(tick_of(ACT_HEADING, 360, 359, 180, 1, 20));
		send_tick(tick_of(ACT_HEADING, 0, 359, 47, 0, -20));
		send_tick(tick_of(ACT_HEADING, 359, 0, 48, 1, 31));
		send_tick(tick_of(ACT_HEADING, 100, 104, 179, 1, -32));
		send_tick(tick_of(ACT_HEADING, 100, 95, 90, 0, 5));
		// wind above range saturates
		send_tick(tick_of(ACT_CLOSE_HAULED, 0, 10, 255, 0, 0));
		send_tick(tick_of(ACT_CLOSE_HAULED, 0, 10, 181, 1, 0));
		send_tick(tick_of(ACT_BEAM_REACH, 0, 200, 90, 0, 10));
		send_tick(tick_of(ACT_BEAM_REACH, 0, 200, 96, 1, 10));
		// built heading below zero, then above 360
		send_tick(tick_of(ACT_BROAD_REACH, 0, 300, 0, 0, -10));
		send_tick(tick_of(ACT_BROAD_REACH, 0, 300, 0, 1, -10));
		send_tick(tick_of(ACT_CLOSE_HAULED, 0, 359, 180, 0, 3));
		send_tick(tick_of(ACT_CLOSE_HAULED, 0, 0, 180, 1, 3));
		// headings beyond the compass range
		send_tick(tick_of(ACT_HEADING, 511, 511, 0, 0, 3));
		send_tick(tick_of(ACT_HEADING, 0, 400, 0, 1, 3));
		// drive the heel estimate to its ceiling
		for (int i = 0; i < 6; i++)
			send_tick(tick_of(ACT_HEADING, 200, 200, 100, i % 2, 31));
		run_random(RandomPerPhase, 1'b0);

		for (int p = 1; p < 8; p++) begin
			drain();
			case (p)
			1: apply_setting(0, 0, 0, 0, 0, 0, 0, 0);
			2: apply_setting(180, 45, 180, 180, 45, 180, 180, 180);
			3: apply_setting(90, 10, 150, 40, 20, 30, 100, 160);
			4: apply_setting(98, 5, 55, 130, 5, 50, 90, 135);
			default: begin
				apply_setting($urandom_range(0, 180), $urandom_range(0, 45),
					$urandom_range(0, 180), $urandom_range(0, 180), $urandom_range(0, 45),
					$urandom_range(0, 180), $urandom_range(0, 180), $urandom_range(0, 180));
			end
			endcase
			if (p == 1) begin
				// zero center minus heel saturates at the bottom
				send_tick(tick_of(ACT_HEADING, 10, 10, 0, 0, 31));
				send_tick(tick_of(ACT_HEADING, 10, 10, 0, 0, 31));
				send_tick(tick_of(ACT_HEADING, 10, 10, 0, 1, 31));
			end
			run_random(RandomPerPhase, p == 4);
		end

		drain();
		if (errors == 0)
			$display("sail_rudder_autopilot_step regression: pass");
		else
			$display("sail_rudder_autopilot_step regression: fail");
		$finish;
	end

endmodule
